FILE: rtl/core/bracket_match_repair_unit_macros.svh
// assertion macros shared by the bracket match repair rtl
// included by files that carry concurrent assertions; no other dependencies
`ifndef BRACKET_MATCH_REPAIR_UNIT_MACROS_SVH
`define BRACKET_MATCH_REPAIR_UNIT_MACROS_SVH

`ifndef SYNTH
// implication in the same cycle
`define BMR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmr assertion failed");
// implication in the next cycle
`define BMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmr assertion failed");
`else
`define BMR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BMR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/bmr_pkg.sv
// types, character codes and bracket decode functions for the bracket match repair unit
// no dependencies
`timescale 1ns / 1ps

package bmr_pkg;

    localparam int BMR_STACK_DEPTH = 1024;
    localparam int POS_W           = 10;
    localparam logic [POS_W-1:0] POS_MAX = 10'd1023;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_ROUND  = 2'd0;
    localparam t_kind KIND_SQUARE = 2'd1;
    localparam t_kind KIND_CURLY  = 2'd2;

    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CH_SPACE        = 8'h20;

    typedef struct packed {
        logic  push;
        logic  pop;
        logic  clear;
        t_kind kind;
    } t_stack_op;

    typedef struct packed {
        logic  empty;
        logic  full;
        t_kind top;
    } t_stack_stat;

    function automatic logic is_opener(input logic [7:0] c);
        return (c == CH_OPEN_ROUND) || (c == CH_OPEN_SQUARE) || (c == CH_OPEN_CURLY);
    endfunction

    function automatic logic is_closer(input logic [7:0] c);
        return (c == CH_CLOSE_ROUND) || (c == CH_CLOSE_SQUARE) || (c == CH_CLOSE_CURLY);
    endfunction

    function automatic t_kind kind_of_opener(input logic [7:0] c);
        t_kind k;
        k = KIND_CURLY;
        if (c == CH_OPEN_ROUND) k = KIND_ROUND;
        else if (c == CH_OPEN_SQUARE) k = KIND_SQUARE;
        return k;
    endfunction

    function automatic t_kind kind_of_closer(input logic [7:0] c);
        t_kind k;
        k = KIND_CURLY;
        if (c == CH_CLOSE_ROUND) k = KIND_ROUND;
        else if (c == CH_CLOSE_SQUARE) k = KIND_SQUARE;
        return k;
    endfunction

    function automatic t_kind clamp_kind(input t_kind k);
        return (k > KIND_CURLY) ? KIND_CURLY : k;
    endfunction

    function automatic logic [7:0] closer_of_kind(input t_kind k);
        logic [7:0] c;
        case (clamp_kind(k))
            KIND_ROUND:  c = CH_CLOSE_ROUND;
            KIND_SQUARE: c = CH_CLOSE_SQUARE;
            default:     c = CH_CLOSE_CURLY;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/bmr_if.sv
// valid/ready channel interfaces for the input byte and the repaired result item
// depends on nothing
`timescale 1ns / 1ps

interface bmr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface bmr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       keep;
    logic       bracket_error;
    logic [9:0] position;
    logic       overflow;
    logic       end_mark;

    modport source (output valid, output out_char, output keep, output bracket_error,
                    output position, output overflow, output end_mark, input ready);
    modport sink   (input valid, input out_char, input keep, input bracket_error,
                    input position, input overflow, input end_mark, output ready);
endinterface

FILE: rtl/core/bmr_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bmr_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/bmr_stack.sv
// bracket stack: cached top of stack, depth counter and ram for the entries below the top
// depends on bmr_pkg, bmr_ram and the assertion macro header
`timescale 1ns / 1ps
`include "bracket_match_repair_unit_macros.svh"

module bmr_stack
    import bmr_pkg::*;
#(
    parameter int STACK_DEPTH = BMR_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_stack_op   i_op,
    output t_stack_stat o_stat
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = $clog2(STACK_DEPTH);

    logic [DEPTH_W-1:0] r_depth, n_depth;
    t_kind              r_top, n_top;
    logic               r_fwd_v, n_fwd_v;
    t_kind              r_fwd_d;

    logic               w_empty, w_full;
    logic [DEPTH_W-1:0] w_dm1, w_nm2;
    logic               w_wr_en;
    logic [ADDR_W-1:0]  w_wr_addr, w_rd_addr;
    t_kind              w_rd_data, w_below;

    assign w_empty = (r_depth == '0);
    assign w_full  = (r_depth == DEPTH_W'(STACK_DEPTH));

    // entry just under the top, from ram or from last cycle's write
    assign w_below = r_fwd_v ? r_fwd_d : w_rd_data;

    always_comb begin
        n_depth = r_depth;
        n_top   = r_top;
        if (i_op.clear) begin
            n_depth = '0;
        end else if (i_op.push && !w_full) begin
            n_depth = r_depth + DEPTH_W'(1);
            n_top   = i_op.kind;
        end else if (i_op.pop) begin
            n_depth = r_depth - DEPTH_W'(1);
            n_top   = w_below;
        end
    end

    // old top spills to ram on a push
    assign w_dm1     = r_depth - DEPTH_W'(1);
    assign w_nm2     = n_depth - DEPTH_W'(2);
    assign w_wr_en   = i_op.push && !w_full && !w_empty;
    assign w_wr_addr = w_dm1[ADDR_W-1:0];
    assign w_rd_addr = w_nm2[ADDR_W-1:0];
    assign n_fwd_v   = w_wr_en && (w_wr_addr == w_rd_addr);

    bmr_ram #(
        .WIDTH ($bits(t_kind)),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_top),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_fwd_v <= 1'b0;
        end else begin
            r_depth <= n_depth;
            r_fwd_v <= n_fwd_v;
        end
        r_top   <= n_top;
        r_fwd_d <= r_top;
    end

    assign o_stat.empty = w_empty;
    assign o_stat.full  = w_full;
    assign o_stat.top   = r_top;

    `BMR_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, i_op.pop, !w_empty)
    `BMR_ASSERT_NEXT(a_clear_zero, i_clk, i_rst_n, i_op.clear, r_depth == '0)
    `BMR_ASSERT_NEXT(a_push_top, i_clk, i_rst_n, i_op.push && !w_full && !i_op.clear,
                     (r_top == $past(i_op.kind)) && (r_depth == $past(r_depth) + DEPTH_W'(1)))

endmodule

FILE: rtl/core/bracket_match_repair_unit.sv
// Bracket match repair unit. Takes one text byte per cycle and returns one result item per
// byte: the byte or its repaired closer, keep/error/overflow flags, position and end mark.
// An item is accepted every cycle while the result side takes items; each result item is
// registered. The open brackets sit in a ram of STACK_DEPTH two-bit entries with the top
// cached in a register, and the ram read for the entry under the top is issued the cycle
// before, so a push or a pop finishes in the cycle of its byte. No clearing pass is needed
// after reset. Depends on bmr_pkg, bmr_if, bmr_stack and the assertion macro header.
`timescale 1ns / 1ps
`include "bracket_match_repair_unit_macros.svh"

module bracket_match_repair_unit
    import bmr_pkg::*;
#(
    parameter int STACK_DEPTH = BMR_STACK_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmr_in_if.sink     i_in,
    bmr_out_if.source  o_out
);

    logic             w_acc;
    logic             w_open, w_close, w_space, w_mismatch;
    t_kind            w_ck;
    t_stack_op        w_op;
    t_stack_stat      w_stat;

    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_char, n_out_char;
    logic             r_keep, n_keep;
    logic             r_err, n_err;
    logic [POS_W-1:0] r_pos;
    logic             r_ovf, n_ovf;
    logic             r_end;
    logic [POS_W-1:0] r_index, n_index;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;

    assign w_open     = is_opener(i_in.ch);
    assign w_close    = is_closer(i_in.ch);
    assign w_space    = (i_in.ch == CH_SPACE);
    assign w_ck       = kind_of_closer(i_in.ch);
    assign w_mismatch = (clamp_kind(w_stat.top) != w_ck);

    assign w_op.push  = w_acc && w_open;
    assign w_op.pop   = w_acc && w_close && !w_stat.empty;
    assign w_op.clear = w_acc && i_in.last;
    assign w_op.kind  = kind_of_opener(i_in.ch);

    bmr_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .o_stat  (w_stat)
    );

    always_comb begin
        n_out_char = i_in.ch;
        n_keep     = 1'b1;
        n_err      = 1'b0;
        n_ovf      = 1'b0;
        if (w_open) begin
            n_ovf = w_stat.full;
        end else if (w_close) begin
            if (w_stat.empty) begin
                n_err  = 1'b1;
                n_keep = 1'b0;
            end else if (w_mismatch) begin
                n_err      = 1'b1;
                n_out_char = closer_of_kind(w_stat.top);
            end
        end else if (w_space) begin
            n_keep = 1'b0;
        end
    end

    always_comb begin
        n_index = r_index;
        if (w_acc) begin
            if (i_in.last) begin
                n_index = '0;
            end else if (r_index < POS_MAX) begin
                n_index = r_index + POS_W'(1);
            end
        end
    end

    assign n_out_valid = w_acc || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_index     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_index     <= n_index;
        end
        if (w_acc) begin
            r_out_char <= n_out_char;
            r_keep     <= n_keep;
            r_err      <= n_err;
            r_pos      <= r_index;
            r_ovf      <= n_ovf;
            r_end      <= i_in.last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_char      = r_out_char;
    assign o_out.keep          = r_keep;
    assign o_out.bracket_error = r_err;
    assign o_out.position      = r_pos;
    assign o_out.overflow      = r_ovf;
    assign o_out.end_mark      = r_end;

    `BMR_ASSERT_NEXT(a_acc_valid, i_clk, i_rst_n, w_acc, r_out_valid)
    `BMR_ASSERT_NEXT(a_empty_drop, i_clk, i_rst_n, w_acc && w_close && w_stat.empty,
                     r_err && !r_keep)
    `BMR_ASSERT_NEXT(a_last_index, i_clk, i_rst_n, w_acc && i_in.last, r_index == '0)

endmodule
